// ===== sv/roll_glitch_filter_recorder_unit_assert.svh =====
// Assertion macros for the block's top-level module.
// Each macro expects signals named clk and arst_n in the using scope.
`ifndef ROLL_GLITCH_FILTER_RECORDER_UNIT_ASSERT_SVH
`define ROLL_GLITCH_FILTER_RECORDER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RGFR_ASSERT_IMPLIES(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RGFR_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// ===== sv/rgfr_pkg.sv =====
package rgfr_pkg;

	// Ring geometry.
	localparam int FILT_DEPTH = 32;
	localparam int UNF_DEPTH  = 32;
	localparam int FILT_AW    = (FILT_DEPTH > 1) ? $clog2(FILT_DEPTH) : 1;
	localparam int UNF_AW     = (UNF_DEPTH > 1) ? $clog2(UNF_DEPTH) : 1;

	// Filter constants.
	localparam logic [14:0] THR_RESET   = 15'd858;
	localparam logic [14:0] MAG_MAX     = 15'h7FFF;
	localparam logic [1:0]  INIT_TARGET = 2'd3;
	localparam logic [2:0]  WIN_MIN     = 3'd3;
	localparam logic [2:0]  WIN_MAX     = 3'd5;
	localparam logic [2:0]  RUN_LIMIT   = 3'd3;
	localparam logic [2:0]  RUN_MAX     = 3'd7;

	// Command codes.
	localparam logic [1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [1:0] CMD_CLEAR   = 2'd1;
	localparam logic [1:0] CMD_RD_FILT = 2'd2;
	localparam logic [1:0] CMD_RD_UNF  = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_INIT_COLLECT = 3'd0;
	localparam logic [2:0] ST_INIT_ACCEPT  = 3'd1;
	localparam logic [2:0] ST_INIT_CLEARED = 3'd2;
	localparam logic [2:0] ST_ACCEPTED     = 3'd3;
	localparam logic [2:0] ST_SKIPPED      = 3'd4;
	localparam logic [2:0] ST_SKIP_REINIT  = 3'd5;
	localparam logic [2:0] ST_DONE         = 3'd6;
	localparam logic [2:0] ST_BAD_INDEX    = 3'd7;

	typedef struct packed {
		logic [1:0]        command;
		logic signed [15:0] roll;
		logic [7:0]        ring_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [14:0] trip_left;
		logic [14:0] trip_right;
		logic [14:0] read_value;
		logic [7:0]  filtered_write_position;
	} out_item_t;

	// Per-item decision from the sample controller to the ring side.
	typedef struct packed {
		logic [2:0]         status;
		logic [14:0]        trip_left;
		logic [14:0]        trip_right;
		logic [7:0]         fpos;
		logic [14:0]        mag;
		logic               f_we;
		logic [FILT_AW-1:0] f_addr;
		logic               f_clear;
		logic               u_we;
		logic [UNF_AW-1:0]  u_addr;
		logic               rd_ok;
	} step_t;

endpackage

// ===== sv/rgfr_ram.sv =====
module rgfr_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port; read data holds when idle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/rgfr_sample_ctrl.sv =====
module rgfr_sample_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [14:0]        cfg_wr_data,
	input  logic               go,
	input  rgfr_pkg::in_item_t item,
	output rgfr_pkg::step_t    step
);
	import rgfr_pkg::*;

	logic [14:0]        thr_q;
	logic [1:0]         acc_q, acc_n;
	logic [2:0]         wc_q, wc_n, wc_inc;
	logic signed [15:0] hi_q, lo_q, last_q, hi_n, lo_n, last_n, hi_c, lo_c;
	logic [2:0]         jr_q, jr_n;
	logic [FILT_AW-1:0] fptr_q, fptr_n, fptr_inc;
	logic [UNF_AW-1:0]  uptr_q, uptr_inc;
	logic [14:0]        left_q, right_q, left_n, right_n;
	logic signed [15:0] r;
	logic [14:0]        mag;
	logic [16:0]        spread, diff, adiff;
	logic               spread_ok, jump, in_range;
	logic [2:0]         status;
	logic               f_we, u_we, f_clear;

	assign r = item.roll;

	// Saturating magnitude: the most negative code maps to full scale.
	always_comb begin
		if (r == 16'sh8000) begin
			mag = MAG_MAX;
		end else if (r[15]) begin
			mag = 15'(-r);
		end else begin
			mag = r[14:0];
		end
	end

	// Window bounds, spread and step size.
	assign hi_c      = (wc_q == 3'd0 || r > hi_q) ? r : hi_q;
	assign lo_c      = (wc_q == 3'd0 || r < lo_q) ? r : lo_q;
	assign wc_inc    = (wc_q < WIN_MAX) ? wc_q + 3'd1 : wc_q;
	assign spread    = {hi_c[15], hi_c} - {lo_c[15], lo_c};
	assign spread_ok = spread < {2'b00, thr_q};
	assign diff      = {last_q[15], last_q} - {r[15], r};
	assign adiff     = diff[16] ? 17'(-diff) : diff;
	assign jump      = adiff > {2'b00, thr_q};

	assign fptr_inc = (fptr_q == FILT_AW'(FILT_DEPTH - 1)) ? '0 : fptr_q + 1'b1;
	assign uptr_inc = (uptr_q == UNF_AW'(UNF_DEPTH - 1)) ? '0 : uptr_q + 1'b1;

	// Range check for ring reads.
	always_comb begin
		if (item.command == CMD_RD_FILT) begin
			in_range = {1'b0, item.ring_index} < 9'(FILT_DEPTH);
		end else begin
			in_range = {1'b0, item.ring_index} < 9'(UNF_DEPTH);
		end
	end

	// Next-state and status decision for one item.
	always_comb begin
		acc_n   = acc_q;
		wc_n    = wc_q;
		hi_n    = hi_q;
		lo_n    = lo_q;
		last_n  = last_q;
		jr_n    = jr_q;
		fptr_n  = fptr_q;
		left_n  = left_q;
		right_n = right_q;
		f_we    = 1'b0;
		u_we    = 1'b0;
		f_clear = 1'b0;
		status  = ST_DONE;
		unique case (item.command)
			CMD_SAMPLE: begin
				u_we = 1'b1;
				if (acc_q < INIT_TARGET) begin
					hi_n = hi_c;
					lo_n = lo_c;
					wc_n = wc_inc;
					if (wc_inc < WIN_MIN) begin
						status = ST_INIT_COLLECT;
					end else if (spread_ok) begin
						last_n = r;
						acc_n  = acc_q + 2'd1;
						status = ST_INIT_ACCEPT;
					end else begin
						acc_n  = '0;
						wc_n   = '0;
						status = ST_INIT_CLEARED;
					end
				end else if (jump) begin
					if (jr_q < RUN_LIMIT) begin
						status = ST_SKIPPED;
					end else begin
						status = ST_SKIP_REINIT;
						acc_n  = '0;
						wc_n   = '0;
					end
					if (jr_q < RUN_MAX) begin
						jr_n = jr_q + 3'd1;
					end
				end else begin
					jr_n   = '0;
					last_n = r;
					f_we   = 1'b1;
					fptr_n = fptr_inc;
					status = ST_ACCEPTED;
					if (!r[15] && r != 16'sd0 && mag > right_q) begin
						right_n = mag;
					end
					if (r[15] && mag > left_q) begin
						left_n = mag;
					end
				end
			end
			CMD_CLEAR: begin
				f_clear = 1'b1;
				fptr_n  = '0;
				left_n  = '0;
				right_n = '0;
			end
			CMD_RD_FILT, CMD_RD_UNF: begin
				status = in_range ? ST_DONE : ST_BAD_INDEX;
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	// Filter state and configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RESET;
			acc_q   <= '0;
			wc_q    <= '0;
			hi_q    <= '0;
			lo_q    <= '0;
			last_q  <= '0;
			jr_q    <= '0;
			fptr_q  <= '0;
			uptr_q  <= '0;
			left_q  <= '0;
			right_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				thr_q <= cfg_wr_data;
			end
			if (go) begin
				acc_q   <= acc_n;
				wc_q    <= wc_n;
				hi_q    <= hi_n;
				lo_q    <= lo_n;
				last_q  <= last_n;
				jr_q    <= jr_n;
				fptr_q  <= fptr_n;
				left_q  <= left_n;
				right_q <= right_n;
				if (u_we) begin
					uptr_q <= uptr_inc;
				end
			end
		end
	end

	always_comb begin
		step.status     = status;
		step.trip_left  = left_n;
		step.trip_right = right_n;
		step.fpos       = 8'(fptr_n);
		step.mag        = mag;
		step.f_we       = f_we;
		step.f_addr     = fptr_q;
		step.f_clear    = f_clear;
		step.u_we       = u_we;
		step.u_addr     = uptr_q;
		step.rd_ok      = in_range;
	end

endmodule

// ===== sv/roll_glitch_filter_recorder_unit.sv =====
// Roll glitch filter and recorder.
// Input channel (in_valid / in_stall / in_data) carries one command per
// transfer: a roll sample, a clear of the filtered record, or a read of
// the filtered or unfiltered ring. Each input transfer yields exactly one
// output transfer (out_valid / out_stall / out_data), in order.
// The jump threshold is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while idle, as the block itself does not enforce this.
// The input transfer loads stage one, which waits on the registered read of
// the ring memories; the next stage is the output register.
// Throughput: one item per cycle while out_stall is low; all filter state
// is updated in the accepting cycle and each ring memory has one write and
// one read port. When out_stall is high and the output register is full,
// it and the stage behind it hold; in_stall rises only once both are full.
// Reset (arst_n low) empties the pipeline, restores the default threshold
// and zeroes the filter state; both rings read as zero until written, with
// no clearing pass after reset.
module roll_glitch_filter_recorder_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [14:0]         cfg_wr_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  rgfr_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output rgfr_pkg::out_item_t out_data
);
	import rgfr_pkg::*;
	`include "roll_glitch_filter_recorder_unit_assert.svh"

	step_t              step;
	logic               accept, adv_s1;
	logic               valid_s1_q, out_valid_q;
	logic [2:0]         status_s1;
	logic [14:0]        left_s1, right_s1;
	logic [7:0]         fpos_s1;
	logic               rd_f_s1, rd_u_s1, hit_s1;
	out_item_t          out_q;
	logic [FILT_DEPTH-1:0] fvalid_q;
	logic [UNF_DEPTH-1:0]  uvalid_q;
	logic               f_re, u_re, f_hit, u_hit;
	logic [14:0]        f_rdata, u_rdata, read_value;

	// Transfer control: stage one moves on when the output register frees up.
	assign adv_s1    = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1_q && !adv_s1;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	rgfr_sample_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.go          (accept),
		.item        (in_data),
		.step        (step)
	);

	// Ring reads issued in the accepting cycle.
	assign f_re  = accept && in_data.command == CMD_RD_FILT;
	assign u_re  = accept && in_data.command == CMD_RD_UNF;
	assign f_hit = step.rd_ok && fvalid_q[in_data.ring_index[FILT_AW-1:0]];
	assign u_hit = step.rd_ok && uvalid_q[in_data.ring_index[UNF_AW-1:0]];

	rgfr_ram #(.WIDTH(15), .DEPTH(FILT_DEPTH)) u_filt_ram (
		.clk   (clk),
		.we    (accept && step.f_we),
		.waddr (step.f_addr),
		.wdata (step.mag),
		.re    (f_re),
		.raddr (in_data.ring_index[FILT_AW-1:0]),
		.rdata (f_rdata)
	);

	rgfr_ram #(.WIDTH(15), .DEPTH(UNF_DEPTH)) u_unf_ram (
		.clk   (clk),
		.we    (accept && step.u_we),
		.waddr (step.u_addr),
		.wdata (step.mag),
		.re    (u_re),
		.raddr (in_data.ring_index[UNF_AW-1:0]),
		.rdata (u_rdata)
	);

	// Written-entry flags; an unwritten or cleared entry reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= '0;
			uvalid_q <= '0;
		end else if (accept) begin
			if (step.f_clear) begin
				fvalid_q <= '0;
			end else if (step.f_we) begin
				fvalid_q[step.f_addr] <= 1'b1;
			end
			if (step.u_we) begin
				uvalid_q[step.u_addr] <= 1'b1;
			end
		end
	end

	// Stage one: results of the filter, waiting on the ring read data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
		end else if (accept) begin
			valid_s1_q <= 1'b1;
		end else if (adv_s1) begin
			valid_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= step.status;
			left_s1   <= step.trip_left;
			right_s1  <= step.trip_right;
			fpos_s1   <= step.fpos;
			rd_f_s1   <= f_re;
			rd_u_s1   <= u_re;
			hit_s1    <= f_re ? f_hit : u_hit;
		end
	end

	// Pick the ring data; anything but a valid, written entry gives zero.
	always_comb begin
		if (rd_f_s1 && hit_s1) begin
			read_value = f_rdata;
		end else if (rd_u_s1 && hit_s1) begin
			read_value = u_rdata;
		end else begin
			read_value = '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1_q) begin
			out_q.status                  <= status_s1;
			out_q.trip_left               <= left_s1;
			out_q.trip_right              <= right_s1;
			out_q.read_value              <= read_value;
			out_q.filtered_write_position <= fpos_s1;
		end
	end

	// A clear leaves every filtered entry reading as zero.
	`RGFR_ASSERT_NEXT(a_clear_flags, accept && in_data.command == CMD_CLEAR, fvalid_q == '0, "filtered flags not cleared")
	// A full, blocked pipeline keeps its middle stage.
	`RGFR_ASSERT_NEXT(a_s1_hold, valid_s1_q && out_valid_q && out_stall, valid_s1_q && $stable(status_s1), "stage one lost while blocked")
	// A bad index never returns data.
	`RGFR_ASSERT_IMPLIES(a_bad_zero, out_valid_q && out_q.status == ST_BAD_INDEX, out_q.read_value == 15'd0, "bad index returned data")
	// The filtered write position stays inside the ring.
	`RGFR_ASSERT_IMPLIES(a_fpos_range, out_valid_q, {1'b0, out_q.filtered_write_position} < 9'(FILT_DEPTH), "filtered position out of range")

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import rgfr_pkg::*;

	localparam int ROLL_LIMIT      = 25736;
	localparam int THR_LIMIT       = 25736;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 182;
	localparam int CYCLE_LIMIT     = 400000;

	// Tracks the filter and ring state and holds the results still owed by the block.
	class roll_filter_scoreboard;
		logic [14:0] threshold;
		int          accepted_cnt;
		int          window_cnt;
		int          window_hi;
		int          window_lo;
		int          last_good;
		int          jump_run;
		logic [14:0] filt_ring[FILT_DEPTH];
		logic [14:0] unf_ring[UNF_DEPTH];
		int          filt_ptr;
		int          unf_ptr;
		logic [14:0] left_peak;
		logic [14:0] right_peak;
		out_item_t   predicted_results[$];
		int          errors;

		function new();
			threshold = THR_RESET;
			accepted_cnt = 0;
			window_cnt = 0;
			window_hi = 0;
			window_lo = 0;
			last_good = 0;
			jump_run = 0;
			foreach (unf_ring[i]) unf_ring[i] = '0;
			unf_ptr = 0;
			clear_record();
			errors = 0;
		endfunction

		function void clear_record();
			foreach (filt_ring[i]) filt_ring[i] = '0;
			filt_ptr = 0;
			left_peak = '0;
			right_peak = '0;
		endfunction

		function logic [14:0] magnitude15(int r);
			int m;
			m = (r < 0) ? -r : r;
			return (m > int'(MAG_MAX)) ? MAG_MAX : 15'(m);
		endfunction

		// Runs one roll sample through the startup window or the jump filter.
		function logic [2:0] take_sample(int r);
			logic [14:0] m;
			logic [2:0]  st;
			int          gap;
			m = magnitude15(r);
			unf_ring[unf_ptr] = m;
			unf_ptr = (unf_ptr + 1) % UNF_DEPTH;

			// Startup: the window spread must stay below the threshold.
			if (accepted_cnt < int'(INIT_TARGET)) begin
				if (window_cnt == 0) begin
					window_hi = r;
					window_lo = r;
				end else begin
					if (r > window_hi) window_hi = r;
					if (r < window_lo) window_lo = r;
				end
				if (window_cnt < int'(WIN_MAX)) window_cnt++;
				if (window_cnt < int'(WIN_MIN)) return ST_INIT_COLLECT;
				if (window_hi - window_lo < int'(threshold)) begin
					last_good = r;
					accepted_cnt++;
					return ST_INIT_ACCEPT;
				end
				accepted_cnt = 0;
				window_cnt = 0;
				return ST_INIT_CLEARED;
			end

			// A distance of 32768 or more always exceeds the 15-bit threshold.
			gap = last_good - r;
			if (gap < 0) gap = -gap;
			if (gap > int'(threshold)) begin
				if (jump_run < int'(RUN_LIMIT)) begin
					st = ST_SKIPPED;
				end else begin
					st = ST_SKIP_REINIT;
					accepted_cnt = 0;
					window_cnt = 0;
				end
				if (jump_run < int'(RUN_MAX)) jump_run++;
				return st;
			end

			// Good sample: record it and update the trip peaks.
			jump_run = 0;
			last_good = r;
			filt_ring[filt_ptr] = m;
			filt_ptr = (filt_ptr + 1) % FILT_DEPTH;
			if (r > 0 && m > right_peak) right_peak = m;
			if (r < 0 && m > left_peak) left_peak = m;
			return ST_ACCEPTED;
		endfunction

		function void note_command(in_item_t it);
			out_item_t res;
			int        r;
			res = '0;
			res.status = ST_DONE;
			r = $signed(it.roll);
			case (it.command)
				CMD_SAMPLE: res.status = take_sample(r);
				CMD_CLEAR: clear_record();
				CMD_RD_FILT: begin
					if (it.ring_index < FILT_DEPTH) res.read_value = filt_ring[it.ring_index];
					else res.status = ST_BAD_INDEX;
				end
				default: begin
					if (it.ring_index < UNF_DEPTH) res.read_value = unf_ring[it.ring_index];
					else res.status = ST_BAD_INDEX;
				end
			endcase
			res.trip_left = left_peak;
			res.trip_right = right_peak;
			res.filtered_write_position = 8'(filt_ptr);
			predicted_results.push_back(res);
		endfunction

		function void compare_field(string name, logic [14:0] want, logic [14:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (predicted_results.size() == 0) begin
				$display("%0t: result %h arrived with no command outstanding", $time, got);
				errors++;
				return;
			end
			want = predicted_results.pop_front();
			compare_field("status", 15'(want.status), 15'(got.status));
			compare_field("trip_left", want.trip_left, got.trip_left);
			compare_field("trip_right", want.trip_right, got.trip_right);
			compare_field("read_value", want.read_value, got.read_value);
			compare_field("filtered_write_position", 15'(want.filtered_write_position),
				15'(got.filtered_write_position));
		endfunction

		function int pending();
			return predicted_results.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        cfg_wr_en   = 1'b0;
	logic [14:0] cfg_wr_data = '0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	in_item_t    in_data     = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	out_item_t   out_data;

	roll_filter_scoreboard sb = new();

	bit idle_on  = 1'b1;
	bit stall_on = 1'b1;
	int cur_thr  = THR_RESET;
	int walk     = 0;
	int jump_left = 0;
	int cycle_count = 0;

	roll_glitch_filter_recorder_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watch both channels; every transfer is seen at the edge that completes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) sb.note_command(in_data);
			if (out_valid && !out_stall) sb.check_result(out_data);
		end
	end

	// Guard against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL roll_glitch_filter_recorder_unit");
			$finish;
		end
	end

	// Output back-pressure in short random bursts.
	initial begin
		forever begin
			@(posedge clk);
			if (stall_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Present one command and hold it until the transfer completes.
	task automatic send_command(logic [1:0] cmd, logic signed [15:0] roll, logic [7:0] idx);
		if (idle_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{command: cmd, roll: roll, ring_index: idx};
		do @(posedge clk); while (in_stall);
	endtask

	// Stop sending and wait until every owed result has been transferred.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_threshold(int value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= 15'(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.threshold = 15'(value);
		cur_thr = value;
	endtask

	// Mostly a random walk within the threshold, with jump runs, noise and ring traffic.
	task automatic random_item();
		int sel;
		int r;
		int step;
		logic [7:0] idx;
		sel = $urandom_range(0, 99);
		if (jump_left == 0 && sel >= 60 && sel < 68) jump_left = $urandom_range(1, 5);
		if (jump_left > 0) begin
			jump_left--;
			step = cur_thr + 1 + $urandom_range(0, 3000);
			r = ($urandom_range(0, 1) == 1) ? walk + step : walk - step;
			if (r > ROLL_LIMIT) r = walk - step;
			if (r < -ROLL_LIMIT) r = int'($urandom_range(0, 2 * ROLL_LIMIT)) - ROLL_LIMIT;
			send_command(CMD_SAMPLE, 16'(r), 8'($urandom));
		end else if (sel < 70) begin
			r = walk + int'($urandom_range(0, cur_thr)) - cur_thr / 2;
			if (r > ROLL_LIMIT) r = ROLL_LIMIT;
			if (r < -ROLL_LIMIT) r = -ROLL_LIMIT;
			walk = r;
			send_command(CMD_SAMPLE, 16'(r), 8'($urandom));
		end else if (sel < 75) begin
			r = int'($urandom_range(0, 65535)) - 32768;
			send_command(CMD_SAMPLE, 16'(r), 8'($urandom));
		end else if (sel < 78) begin
			send_command(CMD_CLEAR, 16'($urandom), 8'($urandom));
		end else begin
			idx = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 31));
			send_command(($urandom_range(0, 1) == 1) ? CMD_RD_FILT : CMD_RD_UNF,
				16'($urandom), idx);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the default threshold.
		send_command(CMD_RD_FILT, 16'sd0, 8'd0);
		send_command(CMD_RD_UNF, -16'sd1, 8'd255);
		send_command(CMD_RD_FILT, 16'sd0, 8'd32);
		send_command(CMD_SAMPLE, 16'sd100, 8'd0);
		send_command(CMD_SAMPLE, 16'sd200, 8'd0);
		send_command(CMD_SAMPLE, 16'sd150, 8'd0);
		send_command(CMD_SAMPLE, 16'sd120, 8'd0);
		send_command(CMD_SAMPLE, 16'sd180, 8'd0);
		send_command(CMD_SAMPLE, 16'sd480, 8'd0);
		// The most negative roll saturates its magnitude; then a jump run into restart.
		send_command(CMD_SAMPLE, -16'sd32768, 8'd0);
		send_command(CMD_RD_UNF, 16'sd0, 8'd6);
		send_command(CMD_SAMPLE, 16'sd25736, 8'd0);
		send_command(CMD_SAMPLE, -16'sd25736, 8'd0);
		send_command(CMD_SAMPLE, 16'sd32767, 8'd0);
		send_command(CMD_CLEAR, -16'sd1, 8'hff);
		// Startup again; the jump run survives it, but the next accepted sample clears it, so the next jump is skipped.
		send_command(CMD_SAMPLE, -16'sd500, 8'd0);
		send_command(CMD_SAMPLE, -16'sd400, 8'd0);
		send_command(CMD_SAMPLE, -16'sd450, 8'd0);
		send_command(CMD_SAMPLE, -16'sd420, 8'd0);
		send_command(CMD_SAMPLE, -16'sd480, 8'd0);
		send_command(CMD_SAMPLE, -16'sd1000, 8'd0);
		send_command(CMD_SAMPLE, 16'sd20000, 8'd0);
		send_command(CMD_RD_FILT, 16'sd0, 8'd31);
		send_command(CMD_RD_UNF, 16'sd0, 8'd31);

		// Random phases; each after the first writes a threshold, and the last one runs without idling.
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				drain_results();
				case (ph)
					1: write_threshold(0);
					2: write_threshold(THR_LIMIT);
					3: write_threshold(120);
					6: write_threshold(int'(THR_RESET));
					default: write_threshold($urandom_range(1, THR_LIMIT));
				endcase
			end
			idle_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			stall_on = (ph != PHASES - 1) && ($urandom_range(0, 3) != 0);
			walk = 0;
			jump_left = 0;
			repeat (ITEMS_PER_PHASE) random_item();
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS roll_glitch_filter_recorder_unit");
		end else begin
			$display("FAIL roll_glitch_filter_recorder_unit");
		end
		$finish;
	end

endmodule
